// ----- design/tbp_pkg.sv -----
package tbp_pkg;

  // Table geometry; entry count is a power of two so the low address bits index it.
  localparam int unsigned TABLE_ENTRIES = 2048;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned HISTORY_MAX   = 11;
  localparam int unsigned XOR_W         = (IDX_W > HISTORY_MAX) ? IDX_W : HISTORY_MAX;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned HIST_LEN_W    = 4;
  localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = HIST_LEN_W'(11);

  // 2-bit saturating counters
  localparam int unsigned CTR_W = 2;
  localparam logic [CTR_W-1:0] CTR_MAX   = '1;
  localparam logic [CTR_W-1:0] CTR_MIN   = '0;
  localparam logic [CTR_W-1:0] BIM_RESET = CTR_MAX;
  localparam logic [CTR_W-1:0] GS_RESET  = CTR_MAX;
  localparam logic [CTR_W-1:0] CH_RESET  = CTR_MIN;

  // Bimodal and chooser counters share one word: {bimodal, chooser}
  localparam int unsigned BC_W = 2 * CTR_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } tbp_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } tbp_req_t;

  typedef struct packed {
    logic predicted_taken;
    logic correct;
  } tbp_rsp_t;

  typedef struct packed {
    logic             pred;
    logic             correct;
    logic [CTR_W-1:0] bim_new;
    logic [CTR_W-1:0] gs_new;
    logic [CTR_W-1:0] ch_new;
  } tbp_train_t;

  function automatic logic [CTR_W-1:0] sat_train(input logic [CTR_W-1:0] c, input logic up);
    logic [CTR_W-1:0] r;
    r = c;
    if (up && (c != CTR_MAX)) begin
      r = c + CTR_W'(1);
    end else if (!up && (c != CTR_MIN)) begin
      r = c - CTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- design/tbp_ram.sv -----
module tbp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tbp_train.sv -----
module tbp_train import tbp_pkg::*; (
  input  logic [CTR_W-1:0] bim_ctr_i,
  input  logic [CTR_W-1:0] gs_ctr_i,
  input  logic [CTR_W-1:0] ch_ctr_i,
  input  logic             taken_i,
  output tbp_train_t       train_o
);

  logic bi_pred;
  logic gs_pred;
  logic disagree;
  logic pred;

  always_comb begin
    bi_pred  = bim_ctr_i[CTR_W-1];
    gs_pred  = gs_ctr_i[CTR_W-1];
    disagree = bi_pred ^ gs_pred;
    // chooser upper half picks bimodal on disagreement
    pred     = disagree ? (ch_ctr_i[CTR_W-1] ? bi_pred : gs_pred) : bi_pred;

    train_o.pred    = pred;
    train_o.correct = (pred == taken_i);
    train_o.bim_new = sat_train(bim_ctr_i, taken_i);
    train_o.gs_new  = sat_train(gs_ctr_i, taken_i);
    train_o.ch_new  = disagree ? sat_train(ch_ctr_i, bi_pred == taken_i) : ch_ctr_i;
  end

endmodule

// ----- design/tournament_branch_predictor.sv -----
// Tournament branch predictor: bimodal and gshare tables with a per-address chooser.
// Input channel (in_valid_i / in_ready_o / in_data_i): one resolved branch per
// request, its address and actual outcome. Output channel (out_valid_o /
// out_ready_i / out_data_o): one result per request, the prediction made from the
// tables as they stood before the branch, and whether it matched the outcome.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_history_length_i): the
// number of global history bits folded into the gshare index; write it only while
// no request is in flight. Values above the history depth saturate.
// Each request is handled in turn: the counter memories are read (synchronous
// read) as it is accepted, then the counters are trained and written back, and
// no new request is taken until the lookup of the one before has finished.
// Reset: the counter memories are swept back to their initial values, one entry
// a cycle, and in_ready_o stays low until the sweep is done; configuration
// writes are taken throughout. When the receiver stalls, the result is held in
// the output register; one further request can still be read, and it waits in
// the lookup stage until the output register frees.
module tournament_branch_predictor import tbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tbp_req_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tbp_rsp_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [HIST_LEN_W-1:0] cfg_history_length_i
);

  tbp_state_e state_q, state_d;

  logic [IDX_W-1:0]       clr_q, clr_d;
  logic [IDX_W-1:0]       base_q;
  logic [IDX_W-1:0]       gidx_q;
  logic                   taken_q;
  logic [HISTORY_MAX-1:0] hist_q, hist_d;
  logic [HIST_LEN_W-1:0]  hist_len_q;
  logic                   out_valid_q;
  tbp_rsp_t               out_data_q;

  logic                   in_accept;
  logic                   done;
  logic                   clr_last;

  // Gshare index formation
  logic [IDX_W-1:0]       in_base;
  logic [IDX_W-1:0]       in_gidx;
  logic [HIST_LEN_W:0]    hlen_sat;
  logic [HISTORY_MAX-1:0] hist_mask;

  // Memory ports
  logic                   mem_we;
  logic [IDX_W-1:0]       bc_waddr;
  logic [IDX_W-1:0]       gs_waddr;
  logic [BC_W-1:0]        bc_wdata;
  logic [CTR_W-1:0]       gs_wdata;
  logic [BC_W-1:0]        bc_rdata;
  logic [CTR_W-1:0]       gs_rdata;

  tbp_train_t             train;

  // -------------------------------------------------------------------------
  // Index formation: mask the history to the configured length, saturated to
  // the stored depth, and fold it into the low address bits.
  // -------------------------------------------------------------------------
  always_comb begin
    hlen_sat = ({1'b0, hist_len_q} > (HIST_LEN_W + 1)'(HISTORY_MAX)) ?
               (HIST_LEN_W + 1)'(HISTORY_MAX) : {1'b0, hist_len_q};
    for (int b = 0; b < HISTORY_MAX; b++) begin
      hist_mask[b] = ((HIST_LEN_W + 1)'(b) < hlen_sat);
    end
    in_base = in_data_i.branch_address[IDX_W-1:0];
    in_gidx = IDX_W'(XOR_W'(in_base) ^ XOR_W'(hist_q & hist_mask));
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  assign clr_last  = (clr_q == IDX_W'(TABLE_ENTRIES - 1));
  assign in_accept = in_valid_i && in_ready_o;
  // finish the lookup once the output register can take the result
  assign done      = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP: if (done) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    bc_waddr   = base_q;
    gs_waddr   = gidx_q;
    bc_wdata   = {train.bim_new, train.ch_new};
    gs_wdata   = train.gs_new;
    clr_d      = clr_q;
    hist_d     = hist_q;
    unique case (state_q)
      ST_CLEAR: begin
        // sweep the tables back to their initial counters
        mem_we   = 1'b1;
        bc_waddr = clr_q;
        gs_waddr = clr_q;
        bc_wdata = {BIM_RESET, CH_RESET};
        gs_wdata = GS_RESET;
        clr_d    = clr_q + IDX_W'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_LOOKUP: begin
        // write back trained counters and advance the history together
        mem_we = done;
        if (done) begin
          hist_d = HISTORY_MAX'({hist_q, taken_q});
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hist_q      <= '0;
      hist_len_q  <= HIST_LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hist_q  <= hist_d;
      if (cfg_valid_i && cfg_ready_o) begin
        hist_len_q <= cfg_history_length_i;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request payload and result register: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      base_q  <= in_base;
      gidx_q  <= in_gidx;
      taken_q <= in_data_i.taken;
    end
    if (done) begin
      out_data_q.predicted_taken <= train.pred;
      out_data_q.correct         <= train.correct;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // -------------------------------------------------------------------------
  // Counter memories: bimodal and chooser share the address index, gshare has
  // its own folded index. Read at accept, written at the end of the lookup.
  // -------------------------------------------------------------------------
  tbp_ram #(
    .Width (BC_W),
    .Depth (TABLE_ENTRIES)
  ) u_bc_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (bc_waddr),
    .wdata_i (bc_wdata),
    .re_i    (in_accept),
    .raddr_i (in_base),
    .rdata_o (bc_rdata)
  );

  tbp_ram #(
    .Width (CTR_W),
    .Depth (TABLE_ENTRIES)
  ) u_gs_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (gs_waddr),
    .wdata_i (gs_wdata),
    .re_i    (in_accept),
    .raddr_i (in_gidx),
    .rdata_o (gs_rdata)
  );

  tbp_train u_train (
    .bim_ctr_i (bc_rdata[BC_W-1:CTR_W]),
    .gs_ctr_i  (gs_rdata),
    .ch_ctr_i  (bc_rdata[CTR_W-1:0]),
    .taken_i   (taken_q),
    .train_o   (train)
  );

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_LOOKUP)
    else $error("accepted request did not move to lookup");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (state_q == ST_IDLE) && out_valid_o)
    else $error("finished lookup did not return to idle with a result");

  a_result_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_LOOKUP)
    else $error("result raised outside a lookup");

  a_history_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> hist_q[0] == $past(taken_q))
    else $error("history did not take the resolved outcome");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import tbp_pkg::*;

  localparam int unsigned HALF_PERIOD      = 6;
  localparam int unsigned RESET_CYCLES     = 4;
  localparam int unsigned SETTLE_CYCLES    = 6;   // result latency plus margin
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  localparam int unsigned CHUNK_ITEMS      = 90;
  localparam int unsigned CHUNKS           = 6;
  localparam int unsigned HOT_BRANCHES     = 8;

  // Shadow of the three counter tables and the global history. Every accepted
  // request is run through it at once, and the outcome it yields is queued
  // until the block hands back the matching response.
  class branch_scoreboard;
    logic [CTR_W-1:0]       bim_ctr  [TABLE_ENTRIES];
    logic [CTR_W-1:0]       gs_ctr   [TABLE_ENTRIES];
    logic [CTR_W-1:0]       pick_ctr [TABLE_ENTRIES];
    logic [HISTORY_MAX-1:0] ghist;
    logic [HIST_LEN_W-1:0]  hist_len;
    tbp_rsp_t               outcome_q[$];
    int unsigned            mismatches;

    function new();
      foreach (bim_ctr[i]) begin
        bim_ctr[i]  = BIM_RESET;
        gs_ctr[i]   = GS_RESET;
        pick_ctr[i] = CH_RESET;
      end
      ghist      = '0;
      hist_len   = HIST_LEN_RESET;
      mismatches = 0;
    endfunction

    function void set_history_length(logic [HIST_LEN_W-1:0] len);
      hist_len = len;
    endfunction

    function logic [CTR_W-1:0] nudge(logic [CTR_W-1:0] c, logic up);
      if (up) begin
        return (c == CTR_MAX) ? c : c + 1'b1;
      end
      return (c == CTR_MIN) ? c : c - 1'b1;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    function void note_branch(tbp_req_t req);
      int unsigned            eff_len;
      logic [HISTORY_MAX-1:0] hmask;
      logic [IDX_W-1:0]       base;
      logic [IDX_W-1:0]       gidx;
      logic                   bim_says;
      logic                   gs_says;
      logic                   guess;
      tbp_rsp_t               rsp;
      // clamp lengths beyond the history depth
      eff_len  = (hist_len > HISTORY_MAX) ? HISTORY_MAX : hist_len;
      hmask    = (HISTORY_MAX'(1) << eff_len) - 1'b1;
      base     = req.branch_address[IDX_W-1:0];
      gidx     = base ^ IDX_W'(ghist & hmask);
      bim_says = bim_ctr[base] >= 2;
      gs_says  = gs_ctr[gidx] >= 2;
      if (bim_says == gs_says) begin
        guess = bim_says;
      end else begin
        guess = (pick_ctr[base] >= 2) ? bim_says : gs_says;
        // lean towards whichever table got it right
        pick_ctr[base] = nudge(pick_ctr[base], bim_says == req.taken);
      end
      bim_ctr[base] = nudge(bim_ctr[base], req.taken);
      gs_ctr[gidx]  = nudge(gs_ctr[gidx], req.taken);
      ghist         = {ghist[HISTORY_MAX-2:0], req.taken};
      rsp.predicted_taken = guess;
      rsp.correct         = (guess == req.taken);
      outcome_q.push_back(rsp);
    endfunction

    function void check_result(tbp_rsp_t got);
      tbp_rsp_t want;
      if (outcome_q.size() == 0) begin
        mismatches++;
        $error("response with no request outstanding: predicted_taken %0b correct %0b",
               got.predicted_taken, got.correct);
        return;
      end
      want = outcome_q.pop_front();
      if (got.predicted_taken !== want.predicted_taken) begin
        mismatches++;
        $error("predicted_taken: expected %0b, actual %0b",
               want.predicted_taken, got.predicted_taken);
      end
      if (got.correct !== want.correct) begin
        mismatches++;
        $error("correct: expected %0b, actual %0b", want.correct, got.correct);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  tbp_req_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  tbp_rsp_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [HIST_LEN_W-1:0] cfg_hist_len;

  // idle odds per cycle, in percent, for each side
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          long_hold_pending;

  // a handful of loop-like branches so the tables saturate, disagree and learn
  logic [ADDR_W-1:0] hot_addr   [HOT_BRANCHES];
  int unsigned       hot_period [HOT_BRANCHES];
  int unsigned       hot_count  [HOT_BRANCHES];

  branch_scoreboard sb = new();

  tournament_branch_predictor u_dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .in_data_i            (in_data),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .out_data_o           (out_data),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_history_length_i (cfg_hist_len)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Sample every handshake at the rising edge; inputs only move on the falling
  // edge, so nothing here depends on the order of events within a time step.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_history_length(cfg_hist_len);
      end
      if (in_valid && in_ready) begin
        sb.note_branch(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
    end
  end

  // Receiver: random back-pressure, with the odd long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold the write until the block takes it, then drop valid.
  task automatic write_history_length(input logic [HIST_LEN_W-1:0] len);
    cfg_valid    = 1'b1;
    cfg_hist_len = len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer one resolved branch; valid stays high into the next request unless
  // an idle cycle is drawn.
  task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid               = 1'b1;
    in_data.branch_address = addr;
    in_data.taken          = taken;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_branch();
    int unsigned       roll;
    int unsigned       k;
    logic [ADDR_W-1:0] addr;
    logic              taken;
    roll = $urandom_range(99);
    k    = $urandom_range(HOT_BRANCHES - 1);
    if (roll < 75) begin
      // loop branch: taken every time except on loop exit
      addr  = hot_addr[k];
      taken = (hot_count[k] % hot_period[k]) != (hot_period[k] - 1);
      hot_count[k]++;
    end else if (roll < 85) begin
      addr  = hot_addr[k];
      taken = 1'($urandom_range(1));
    end else if (roll < 92) begin
      // alias onto a hot entry from a different high address
      addr             = $urandom();
      addr[IDX_W-1:0]  = hot_addr[k][IDX_W-1:0];
      taken            = 1'($urandom_range(1));
    end else begin
      addr  = $urandom();
      taken = 1'($urandom_range(1));
    end
    send_branch(addr, taken);
  endtask

  // Pause the sender until every response is back, then let the pipe settle.
  task automatic wait_until_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned chunk;
    int unsigned n;
    in_valid          = 1'b0;
    in_data           = '0;
    cfg_valid         = 1'b0;
    cfg_hist_len      = HIST_LEN_RESET;
    rst_n             = 1'b0;
    long_hold_pending = 1'b0;
    send_idle_pct     = 7;
    recv_idle_pct     = 56;
    for (n = 0; n < HOT_BRANCHES; n++) begin
      hot_addr[n]   = $urandom();
      hot_period[n] = $urandom_range(2, 6);
      hot_count[n]  = 0;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Full history length; the block is still sweeping its tables, so the
    // first request waits on in_ready.
    write_history_length(HIST_LEN_W'(HISTORY_MAX));
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_F800, 1'b0);   // same entry as address zero
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    send_branch(32'h0000_0040, 1'b0);
    send_branch(32'h0000_0040, 1'b0);
    send_branch(32'h0000_0040, 1'b0);
    send_branch(32'h0000_0040, 1'b1);
    send_branch(32'h0000_0040, 1'b0);
    send_branch(32'h0000_07FF, 1'b1);
    send_branch(32'h0000_0800, 1'b0);
    wait_until_drained();

    // Zero history: gshare indexes exactly like bimodal.
    write_history_length('0);
    send_branch(32'h0000_0040, 1'b0);
    send_branch(32'h0000_0040, 1'b0);
    send_branch(32'h0000_0040, 1'b1);
    send_branch(32'h0000_0123, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h8000_0000, 1'b0);
    wait_until_drained();

    // Length above the history depth: must behave as the full depth.
    write_history_length('1);
    send_branch(32'h0000_0040, 1'b1);
    send_branch(32'h0000_0040, 1'b0);
    send_branch(32'h0000_0055, 1'b0);
    send_branch(32'h0000_0055, 1'b1);
    send_branch(32'h0000_07FE, 1'b0);
    send_branch(32'h0000_0001, 1'b1);
    wait_until_drained();

    // Random chunks: sender mostly busy first, then receiver mostly busy, then
    // no idling at all. Each chunk gets a fresh history length.
    for (chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk == 2) begin
        send_idle_pct = 56;
        recv_idle_pct = 7;
      end else if (chunk == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_history_length(HIST_LEN_W'((chunk * 5) % 16));
      for (n = 0; n < CHUNK_ITEMS; n++) begin
        // stall the receiver for a long stretch while requests keep coming
        if (chunk == 4 && n == 20) begin
          long_hold_pending = 1'b1;
        end
        send_random_branch();
      end
      wait_until_drained();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tbp_pkg.sv
design/tbp_ram.sv
design/tbp_train.sv
design/tournament_branch_predictor.sv
dv/tb.sv
